[design/nbfs_pkg.sv]
// Shared types and constants of the nested bracket field splitter.
`timescale 1ns / 1ps

package nbfs_pkg;

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] SEP_RESET  = 8'd44;

    // Entries of the plan queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       token_done;
        logic       nest_overflow;
    } t_result;

    // All results caused by one input byte: one, or two when pair is set.
    typedef struct packed {
        logic    pair;
        t_result first;
        t_result second;
    } t_plan;

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'd32, [8'd9:8'd13]};
    endfunction

endpackage

[design/nbfs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module nbfs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/nbfs_front.sv]
// Front end: classifies each byte, keeps quote and nesting state, builds a result plan.
`timescale 1ns / 1ps

module nbfs_front import nbfs_pkg::*; #(
    parameter int MAX_NEST = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_accept,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    output logic       o_plan_valid,
    output t_plan      o_plan
);

    localparam int DW = $clog2(MAX_NEST + 1);
    localparam int AW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

    logic [7:0]    r_separator, n_separator;
    logic          r_quoted, n_quoted;
    logic [7:0]    r_prev, n_prev;
    logic          r_token_open, n_token_open;
    logic [DW-1:0] r_depth, n_depth;
    logic          r_top, n_top;

    logic          below_bit;
    logic          push_en;
    logic [AW-1:0] raddr;

    logic          is_closer, is_opener, group, want, match;
    logic [1:0]    cnt;
    t_result       keep_r, mark_r, s0, s1;
    logic          tok_after;
    logic [DW-1:0] depth_after;

    always_comb begin
        is_closer = (i_in_byte == CH_RBRACE) || (i_in_byte == CH_RBRACK);
        is_opener = (i_in_byte == CH_LBRACE) || (i_in_byte == CH_LBRACK);
        group     = (r_separator == CH_NUL) && (r_depth == '0);
        want      = (i_in_byte == CH_RBRACK);
        match     = (r_depth != '0) && (r_top == want);

        keep_r.out_byte      = i_in_byte;
        keep_r.byte_valid    = 1'b1;
        keep_r.token_done    = 1'b0;
        keep_r.nest_overflow = 1'b0;
        mark_r.out_byte      = CH_NUL;
        mark_r.byte_valid    = 1'b0;
        mark_r.token_done    = 1'b1;
        mark_r.nest_overflow = 1'b0;

        s0          = keep_r;
        s1          = keep_r;
        cnt         = 2'd1;
        tok_after   = 1'b1;
        depth_after = r_depth;
        n_quoted    = r_quoted;
        n_top       = r_top;
        push_en     = 1'b0;

        if (r_quoted) begin
            if (i_in_byte == CH_QUOTE && r_prev != CH_BSLASH) begin
                n_quoted = 1'b0;
            end
        end else if (is_closer) begin
            if (match) begin
                depth_after = r_depth - DW'(1);
                n_top       = below_bit;
            end
            // a closed top-level group ends its token on the kept closer
            if (depth_after == '0 && r_separator == CH_NUL) begin
                s0.token_done = 1'b1;
                tok_after     = 1'b0;
            end
        end else if (is_opener) begin
            if (group && r_token_open) begin
                s0  = mark_r;
                cnt = 2'd2;
            end
            if (r_depth < DW'(MAX_NEST)) begin
                push_en     = 1'b1;
                depth_after = r_depth + DW'(1);
                n_top       = (i_in_byte == CH_LBRACK);
            end else if (cnt == 2'd2) begin
                s1.nest_overflow = 1'b1;
            end else begin
                s0.nest_overflow = 1'b1;
            end
        end else if (i_in_byte == CH_QUOTE) begin
            n_quoted = 1'b1;
        end else if (r_depth == '0 && i_in_byte == r_separator) begin
            s0        = mark_r;
            cnt       = r_token_open ? 2'd1 : 2'd0;
            tok_after = 1'b0;
        end else if (!r_token_open && is_space(i_in_byte)) begin
            cnt       = 2'd0;
            tok_after = 1'b0;
        end

        n_prev       = i_in_byte;
        n_token_open = tok_after;
        n_depth      = depth_after;

        if (i_end_of_text) begin
            if (tok_after) begin
                if (cnt == 2'd0) begin
                    s0  = mark_r;
                    cnt = 2'd1;
                end else if (cnt == 2'd1) begin
                    s0.token_done = 1'b1;
                end else begin
                    s1.token_done = 1'b1;
                end
            end
            n_quoted     = 1'b0;
            n_prev       = CH_NUL;
            n_token_open = 1'b0;
            n_depth      = '0;
        end

        if (!i_accept) begin
            n_quoted     = r_quoted;
            n_prev       = r_prev;
            n_token_open = r_token_open;
            n_depth      = r_depth;
            n_top        = r_top;
            push_en      = 1'b0;
        end

        n_separator = i_cfg_we ? i_cfg_data : r_separator;

        // prefetch the entry just below the next top of stack
        raddr = (n_depth >= DW'(2)) ? AW'(n_depth - DW'(2)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_separator  <= SEP_RESET;
            r_quoted     <= 1'b0;
            r_prev       <= CH_NUL;
            r_token_open <= 1'b0;
            r_depth      <= '0;
        end else begin
            r_separator  <= n_separator;
            r_quoted     <= n_quoted;
            r_prev       <= n_prev;
            r_token_open <= n_token_open;
            r_depth      <= n_depth;
        end
    end

    // top of stack is only read while the depth is nonzero
    always_ff @(posedge i_clk) begin
        r_top <= n_top;
    end

    nbfs_ram #(
        .WIDTH (1),
        .DEPTH (MAX_NEST)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (push_en),
        .i_waddr (AW'(r_depth)),
        .i_wdata (i_in_byte == CH_LBRACK),
        .i_raddr (raddr),
        .o_rdata (below_bit)
    );

    always_comb begin
        o_plan_valid  = i_accept && (cnt != 2'd0);
        o_plan.pair   = (cnt == 2'd2);
        o_plan.first  = s0;
        o_plan.second = s1;
    end

endmodule

[design/nbfs_queue.sv]
// Short plan queue decoupling the front end from the result back end.
`timescale 1ns / 1ps

module nbfs_queue import nbfs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_enq,
    input  t_plan i_data,
    input  logic  i_deq,
    output logic  o_full,
    output logic  o_empty,
    output t_plan o_head
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_plan         r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_enq) begin
            n_wptr = (r_wptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + AW'(1);
        end
        if (i_deq) begin
            n_rptr = (r_rptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + AW'(1);
        end
        if (i_enq && !i_deq) begin
            n_count = r_count + CW'(1);
        end else if (!i_enq && i_deq) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_enq) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

endmodule

[design/nbfs_back.sv]
// Back end: unpacks queued plans into single results behind an output register.
`timescale 1ns / 1ps

module nbfs_back import nbfs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_plan   i_q_head,
    output logic    o_q_deq,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result,
    output logic    o_last
);

    logic    r_valid, n_valid;
    logic    r_sub, n_sub;
    t_result r_res, n_res;
    logic    r_last, n_last;

    logic    load, last;
    t_result sel;

    always_comb begin
        load    = (!r_valid || i_pop) && !i_q_empty;
        sel     = r_sub ? i_q_head.second : i_q_head.first;
        last    = !i_q_head.pair || r_sub;
        o_q_deq = load && last;

        n_valid = r_valid;
        n_sub   = r_sub;
        n_res   = r_res;
        n_last  = r_last;
        if (load) begin
            n_valid = 1'b1;
            n_sub   = !last;
            n_res   = sel;
            n_last  = last;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sub   <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_last <= n_last;
    end

    assign o_empty  = !r_valid;
    assign o_result = r_res;
    assign o_last   = r_last;

endmodule

[design/nested_bracket_field_splitter.sv]
// Top level of the nested bracket field splitter: front end, plan queue, back end.
//
//   channel   direction  handshake         payload
//   input     in         i_push / o_full   i_in_byte, i_end_of_text
//   result    out        o_empty / i_pop   o_out_byte, o_byte_valid, o_token_done,
//                                          o_nest_overflow, o_last_of_run
//   config    in         i_separator_we    i_separator
//
// One byte is accepted per cycle while the plan queue has room; its classification,
// stack update and result plan are done in that cycle, the top of stack kept in a
// register and the entry below prefetched from the stack RAM. Results leave one per
// cycle through the output register while popped, so a byte with two results holds
// that port for two pops. Reset is synchronous; the stack RAM needs no clearing pass.
`timescale 1ns / 1ps

module nested_bracket_field_splitter import nbfs_pkg::*; #(
    parameter int MAX_NEST = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_token_done,
    output logic       o_nest_overflow,
    output logic       o_last_of_run,
    input  logic       i_separator_we,
    input  logic [7:0] i_separator
);

    logic    q_full, q_empty, q_deq;
    logic    plan_valid;
    logic    accept;
    t_plan   plan, q_head;
    t_result res;

    assign accept = i_push && !q_full;

    nbfs_front #(
        .MAX_NEST (MAX_NEST)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_separator_we),
        .i_cfg_data    (i_separator),
        .i_accept      (accept),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_plan_valid  (plan_valid),
        .o_plan        (plan)
    );

    nbfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_enq   (plan_valid),
        .i_data  (plan),
        .i_deq   (q_deq),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    nbfs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_q_deq   (q_deq),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_result  (res),
        .o_last    (o_last_of_run)
    );

    assign o_full          = q_full;
    assign o_out_byte      = res.out_byte;
    assign o_byte_valid    = res.byte_valid;
    assign o_token_done    = res.token_done;
    assign o_nest_overflow = res.nest_overflow;

`ifndef NO_ASSERTIONS
    // a result without a kept byte is always a token end marker
    a_marker_ends_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !o_byte_valid |-> o_token_done && o_out_byte == CH_NUL)
        else $error("result without byte is not a clean token end marker");

    // overflow is flagged only on a kept opening bracket
    a_overflow_on_opener: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_nest_overflow |->
            o_byte_valid && (o_out_byte == CH_LBRACE || o_out_byte == CH_LBRACK))
        else $error("nest overflow flagged on a result that is no opener");

    // reset leaves both sides open and nothing pending
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty && !o_full)
        else $error("result pending or input blocked after reset");
`endif

endmodule

[sim/nested_bracket_field_splitter_tb.sv]
// Self-checking testbench for the nested bracket field splitter.
`timescale 1ns / 1ps

module nested_bracket_field_splitter_tb import nbfs_pkg::*; ();

    localparam int          STACK_LEVELS = 16;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          LONG_HOLD_CYCLES = 300;
    localparam int          PHASE_ITEMS = 16;
    localparam logic [7:0]  CH_SPACE = 8'h20;
    localparam logic [7:0]  CH_TAB   = 8'h09;
    localparam logic [7:0]  CH_CR    = 8'h0D;
    localparam logic [7:0]  CH_COMMA = 8'h2C;
    localparam logic [7:0]  CH_A     = 8'h61;
    localparam logic [7:0]  CH_B     = 8'h62;
    localparam logic [7:0]  CH_Q     = 8'h71;
    localparam logic [7:0]  CH_X     = 8'h78;
    localparam logic [7:0]  CH_ALL1  = 8'hFF;

    typedef enum logic { ROW_BYTE, ROW_CFG } t_row_kind;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       token_done;
        logic       nest_overflow;
        logic       last_of_run;
    } t_emit;

    // typed rows carry their own results; the others are checked against the splitter model
    typedef struct packed {
        t_row_kind  kind;
        logic [7:0] data;
        logic       eot;
        logic       typed;
        logic [1:0] n_typed;
        t_emit      r0;
        logic       unused;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_push = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_end_of_text = 1'b0;
    logic       i_pop = 1'b0;
    logic       i_separator_we = 1'b0;
    logic [7:0] i_separator = 8'h00;
    logic       o_full;
    logic       o_empty;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_token_done;
    logic       o_nest_overflow;
    logic       o_last_of_run;

    nested_bracket_field_splitter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .o_full          (o_full),
        .i_in_byte       (i_in_byte),
        .i_end_of_text   (i_end_of_text),
        .o_empty         (o_empty),
        .i_pop           (i_pop),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_token_done    (o_token_done),
        .o_nest_overflow (o_nest_overflow),
        .o_last_of_run   (o_last_of_run),
        .i_separator_we  (i_separator_we),
        .i_separator     (i_separator)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // splitter model state
    logic [7:0]              sep_model;
    logic                    in_quote;
    logic [7:0]              prev_byte;
    logic                    tok_open;
    int                      nest_lvl;
    logic [STACK_LEVELS-1:0] bracket_kind;
    t_emit                   step_results[$];
    t_emit                   pending_results[$];

    int error_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int tokens_seen = 0;
    int overflows_seen = 0;
    int tx_idle_pct = 15;
    int rx_idle_pct = 65;
    logic hold_req = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left = 0;

    initial begin
        #2000000;
        $display("timeout: %0d results still pending", pending_results.size());
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input t_emit got, input t_emit want);
        $display("ERROR %0t: %s got byte=%h v=%b done=%b ovf=%b last=%b",
                 $time, what, got.out_byte, got.byte_valid, got.token_done, got.nest_overflow,
                 got.last_of_run, " want byte=%h v=%b done=%b ovf=%b last=%b",
                 want.out_byte, want.byte_valid, want.token_done,
                 want.nest_overflow, want.last_of_run);
        error_count++;
    endtask

    function automatic t_emit mk(input logic [7:0] b, input logic v, input logic d,
                                 input logic o);
        t_emit r;
        r.out_byte = v ? b : 8'h00;
        r.byte_valid = v;
        r.token_done = d;
        r.nest_overflow = o;
        r.last_of_run = 1'b1;
        return r;
    endfunction

    task automatic expect_result(input t_emit r);
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic add_result(input logic [7:0] b, input logic v, input logic d,
                              input logic o);
        t_emit r;
        r = mk(b, v, d, o);
        r.last_of_run = 1'b0;
        step_results.insert(step_results.size(), r);
    endtask

    task automatic keep_char(input logic [7:0] b, input logic o);
        add_result(b, 1'b1, 1'b0, o);
        tok_open = 1'b1;
    endtask

    // end the open token: mark the step's last result, or add a marker
    task automatic close_token();
        if (tok_open) begin
            if (step_results.size() > 0 && !step_results[step_results.size()-1].token_done)
                step_results[step_results.size()-1].token_done = 1'b1;
            else
                add_result(8'h00, 1'b0, 1'b1, 1'b0);
            tok_open = 1'b0;
        end
    endtask

    task automatic split_byte(input logic [7:0] c, input logic eot);
        logic want_kind;
        logic ovf;
        step_results.delete();
        if (in_quote) begin
            keep_char(c, 1'b0);
            if (c == CH_QUOTE && prev_byte != CH_BSLASH) in_quote = 1'b0;
        end else if (c == CH_RBRACE || c == CH_RBRACK) begin
            want_kind = (c == CH_RBRACK);
            keep_char(c, 1'b0);
            // pop only on a matching closer
            if (nest_lvl > 0 && bracket_kind[nest_lvl-1] == want_kind) nest_lvl--;
            if (nest_lvl == 0 && sep_model == CH_NUL) close_token();
        end else if (c == CH_LBRACE || c == CH_LBRACK) begin
            ovf = 1'b0;
            if (nest_lvl == 0 && sep_model == CH_NUL) close_token();
            if (nest_lvl < STACK_LEVELS) begin
                bracket_kind[nest_lvl] = (c == CH_LBRACK);
                nest_lvl++;
            end else begin
                ovf = 1'b1;
            end
            keep_char(c, ovf);
        end else if (c == CH_QUOTE) begin
            keep_char(c, 1'b0);
            in_quote = 1'b1;
        end else if (nest_lvl == 0 && c == sep_model) begin
            close_token();
        end else if (tok_open || !is_space(c)) begin
            keep_char(c, 1'b0);
        end
        prev_byte = c;
        if (eot) begin
            close_token();
            in_quote = 1'b0;
            prev_byte = 8'h00;
            tok_open = 1'b0;
            nest_lvl = 0;
        end
        if (step_results.size() > 0)
            step_results[step_results.size()-1].last_of_run = 1'b1;
    endtask

    task automatic send_row(input t_row r, input t_emit r1);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_in_byte <= r.data;
        i_end_of_text <= r.eot;
        do @(posedge i_clk); while (o_full);
        split_byte(r.data, r.eot);
        items_sent++;
        if (r.typed) begin
            if (r.n_typed > 0) expect_result(r.r0);
            if (r.n_typed > 1) expect_result(r1);
        end else begin
            foreach (step_results[k]) expect_result(step_results[k]);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eot);
        t_row r;
        r = '0;
        r.kind = ROW_BYTE;
        r.data = b;
        r.eot = eot;
        send_row(r, '0);
    endtask

    task automatic write_separator(input logic [7:0] v);
        i_push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_separator_we <= 1'b1;
        i_separator <= v;
        @(posedge i_clk);
        i_separator_we <= 1'b0;
        sep_model = v;
    endtask

    function automatic logic [7:0] pick_separator();
        case ($urandom_range(0, 3))
            0: return CH_NUL;
            1: return SEP_RESET;
            2: return CH_ALL1;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // well-formed expression with random content, or plain noise
    task automatic send_expression(input bit noisy);
        int len;
        int pick;
        int lvl;
        logic [STACK_LEVELS-1:0] kinds;
        logic [7:0] b;
        logic last;
        len = $urandom_range(2, 14);
        lvl = 0;
        kinds = '0;
        if (!noisy && $urandom_range(0, 9) == 0) begin
            // deep nesting, sometimes past the stack limit
            repeat ($urandom_range(14, 18)) send_byte($urandom_range(0, 1) ? CH_LBRACK : CH_LBRACE,
                                                     1'b0);
        end
        for (int k = 0; k < len; k++) begin
            pick = noisy ? 99 : $urandom_range(0, 98);
            if (pick < 25) begin
                b = CH_A + 8'($urandom_range(0, 25));
            end else if (pick < 33) begin
                b = 8'($urandom_range(8, 13));
                if (b == 8'd8) b = CH_SPACE;
            end else if (pick < 45) begin
                b = sep_model;
            end else if (pick < 56) begin
                b = $urandom_range(0, 1) ? CH_LBRACK : CH_LBRACE;
                if (lvl < STACK_LEVELS) begin
                    kinds[lvl] = (b == CH_LBRACK);
                    lvl++;
                end
            end else if (pick < 66) begin
                if (lvl > 0) begin
                    lvl--;
                    b = kinds[lvl] ? CH_RBRACK : CH_RBRACE;
                end else begin
                    b = $urandom_range(0, 1) ? CH_RBRACK : CH_RBRACE;
                end
            end else if (pick < 73) begin
                b = CH_QUOTE;
            end else if (pick < 77) begin
                b = CH_BSLASH;
            end else begin
                b = 8'($urandom_range(0, 255));
            end
            if (noisy) last = ($urandom_range(0, 7) == 0);
            else last = (k == len - 1) && ($urandom_range(0, 9) != 0);
            send_byte(b, last);
        end
    endtask

    // receiver: random pops, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else if (hold_left != 0) begin
            i_pop <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            i_pop <= 1'b0;
            hold_left <= LONG_HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else begin
            i_pop <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_emit got;
        t_emit want;
        if (i_rst_n && i_pop && !o_empty) begin
            got = '{o_out_byte, o_byte_valid, o_token_done, o_nest_overflow, o_last_of_run};
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction:", got, '0);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) report_mismatch("result mismatch:", got, want);
                results_checked++;
                if (got.token_done) tokens_seen++;
                if (got.nest_overflow) overflows_seen++;
            end
        end
    end

    t_row dir_rows[$];

    task automatic add_row(input t_row r);
        dir_rows.insert(dir_rows.size(), r);
    endtask

    initial begin
        sep_model = SEP_RESET;
        in_quote = 1'b0;
        prev_byte = 8'h00;
        tok_open = 1'b0;
        nest_lvl = 0;
        bracket_kind = '0;

        // separator at reset value
        add_row('{ROW_BYTE, CH_SPACE, 1'b0, 1'b1, 2'd0, '0, 1'b0});
        add_row('{ROW_BYTE, CH_A, 1'b0, 1'b1, 2'd1, mk(CH_A, 1'b1, 1'b0, 1'b0), 1'b0});
        add_row('{ROW_BYTE, CH_COMMA, 1'b0, 1'b1, 2'd1, mk(CH_NUL, 1'b0, 1'b1, 1'b0),
                  1'b0});
        add_row('{ROW_BYTE, CH_COMMA, 1'b0, 1'b1, 2'd0, '0, 1'b0});
        add_row('{ROW_BYTE, CH_LBRACE, 1'b0, 1'b0, 2'd0, '0, 1'b0});
        add_row('{ROW_BYTE, CH_COMMA, 1'b0, 1'b0, 2'd0, '0, 1'b0});
        add_row('{ROW_BYTE, CH_RBRACK, 1'b0, 1'b0, 2'd0, '0, 1'b0});
        add_row('{ROW_BYTE, CH_RBRACE, 1'b0, 1'b0, 2'd0, '0, 1'b0});
        add_row('{ROW_BYTE, CH_RBRACE, 1'b0, 1'b0, 2'd0, '0, 1'b0});
        add_row('{ROW_BYTE, CH_QUOTE, 1'b0, 1'b0, 2'd0, '0, 1'b0});
        add_row('{ROW_BYTE, CH_BSLASH, 1'b0, 1'b0, 2'd0, '0, 1'b0});
        add_row('{ROW_BYTE, CH_QUOTE, 1'b0, 1'b0, 2'd0, '0, 1'b0});
        add_row('{ROW_BYTE, CH_LBRACE, 1'b0, 1'b0, 2'd0, '0, 1'b0});
        add_row('{ROW_BYTE, CH_QUOTE, 1'b0, 1'b0, 2'd0, '0, 1'b0});
        add_row('{ROW_BYTE, CH_ALL1, 1'b1, 1'b1, 2'd1, mk(CH_ALL1, 1'b1, 1'b1, 1'b0),
                  1'b0});
        add_row('{ROW_BYTE, CH_NUL, 1'b1, 1'b1, 2'd1, mk(CH_NUL, 1'b1, 1'b1, 1'b0),
                  1'b0});
        add_row('{ROW_BYTE, CH_TAB, 1'b1, 1'b1, 2'd0, '0, 1'b0});
        // zero separator: split at top-level groups
        add_row('{ROW_CFG, CH_NUL, 1'b0, 1'b0, 2'd0, '0, 1'b0});
        add_row('{ROW_BYTE, CH_A, 1'b0, 1'b0, 2'd0, '0, 1'b0});
        add_row('{ROW_BYTE, CH_LBRACK, 1'b0, 1'b0, 2'd0, '0, 1'b0});
        add_row('{ROW_BYTE, CH_X, 1'b0, 1'b0, 2'd0, '0, 1'b0});
        add_row('{ROW_BYTE, CH_RBRACK, 1'b0, 1'b0, 2'd0, '0, 1'b0});
        add_row('{ROW_BYTE, CH_NUL, 1'b0, 1'b0, 2'd0, '0, 1'b0});
        add_row('{ROW_BYTE, CH_B, 1'b0, 1'b0, 2'd0, '0, 1'b0});
        add_row('{ROW_BYTE, CH_NUL, 1'b0, 1'b1, 2'd1, mk(CH_NUL, 1'b0, 1'b1, 1'b0),
                  1'b0});
        add_row('{ROW_BYTE, CH_LBRACE, 1'b1, 1'b0, 2'd0, '0, 1'b0});
        add_row('{ROW_BYTE, CH_CR, 1'b0, 1'b0, 2'd0, '0, 1'b0});
        // all-ones separator
        add_row('{ROW_CFG, CH_ALL1, 1'b0, 1'b0, 2'd0, '0, 1'b0});
        add_row('{ROW_BYTE, CH_Q, 1'b0, 1'b0, 2'd0, '0, 1'b0});
        add_row('{ROW_BYTE, CH_ALL1, 1'b0, 1'b1, 2'd1, mk(CH_NUL, 1'b0, 1'b1, 1'b0),
                  1'b0});
        add_row('{ROW_BYTE, CH_QUOTE, 1'b1, 1'b1, 2'd1, mk(CH_QUOTE, 1'b1, 1'b1, 1'b0),
                  1'b0});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG) write_separator(dir_rows[k].data);
            else send_row(dir_rows[k], '0);
        end
        // fill the nesting stack and push one past it
        repeat (STACK_LEVELS + 1) send_byte(CH_LBRACK, 1'b0);
        send_byte(CH_RBRACK, 1'b1);

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 65 : 0;
            rx_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 15 : 0;
            for (int seg = 0; seg < 2; seg++) begin
                int start_count;
                write_separator(pick_separator());
                // hold the receiver off while the sender keeps offering bytes
                if (phase == 0 && seg == 0) hold_req <= 1'b1;
                start_count = items_sent;
                while (items_sent - start_count < PHASE_ITEMS / 2)
                    send_expression($urandom_range(0, 4) == 0);
            end
        end
        write_separator(CH_NUL);
        send_byte(CH_LBRACE, 1'b1);

        i_push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES * 2) @(posedge i_clk);

        $display("Covered %0d input bytes, %0d results, %0d token ends, %0d stack overflows,",
                 items_sent, results_checked, tokens_seen, overflows_seen);
        $display("under zero, default, all-ones and random separators with varied flow control.");
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
